[src/pfra_pkg.sv]
// Shared constants, codes and types of the page frame allocator.
package pfra_pkg;

    localparam int NUM_PAGES  = 3840;
    localparam int BIT_W      = 6;
    localparam int ROW_BITS   = 1 << BIT_W;
    localparam int ROWS       = (NUM_PAGES + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W      = ROW_W + BIT_W;
    localparam int LIM_W      = IDX_W + 1;
    localparam int CNT_W      = 7;
    localparam int ADDR_W     = 25;
    localparam int FA_W       = 32;
    localparam int PA_W       = 24;
    localparam int ST_W       = 3;
    localparam int OP_W       = 2;
    localparam int SPAN_W     = 15;
    localparam int PAGE_SHIFT = 12;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [FA_W-1:0]   BASE_ADDR  = 32'h0010_0000;
    localparam logic [ADDR_W-1:0] START_RST  = 25'h010_0000;
    localparam logic [ADDR_W-1:0] END_RST    = 25'h100_0000;
    localparam logic [CNT_W-1:0]  USED_COUNT = 7'd100;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_INIT  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    localparam logic [ST_W-1:0] ST_OK     = 3'd0;
    localparam logic [ST_W-1:0] ST_BELOW  = 3'd1;
    localparam logic [ST_W-1:0] ST_NOPAGE = 3'd2;
    localparam logic [ST_W-1:0] ST_FREE   = 3'd3;
    localparam logic [ST_W-1:0] ST_OOM    = 3'd4;

    localparam logic REG_START = 1'b0;
    localparam logic REG_END   = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [FA_W-1:0] addr;
    } t_cmd;

    typedef struct packed {
        logic [ST_W-1:0] status;
        logic [PA_W-1:0] page_addr;
    } t_res;

endpackage

[src/page_frame_refcount_allocator.sv]
// Allocate and free go from idle through their own state to done; initialise sets up the
// window and sweeps the map first. Out of memory, a free refused on its address and no
// operation go straight to done. One word is in work at a time: the next is taken once the
// result enters the output register. Reset sweeps the map to all used, no word accepted.
// Reset also restores both configuration registers and clears the high memory limit.
// Top level of the page frame allocator: stream ports, APB registers, output register.
module page_frame_refcount_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // free_address[31:0]
    input  logic [pfra_pkg::FA_W-1:0]       i_s_axis_tdata,
    // opcode[1:0]
    input  logic [pfra_pkg::OP_W-1:0]       i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // page_address[23:0]
    output logic [pfra_pkg::PA_W-1:0]       o_m_axis_tdata,
    // status[2:0]
    output logic [pfra_pkg::ST_W-1:0]       o_m_axis_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pfra_pkg::PADDR_W-1:0]    paddr,
    input  logic [pfra_pkg::PDATA_W-1:0]    pwdata,
    output logic [pfra_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    logic [pfra_pkg::ADDR_W-1:0] r_start, r_end;
    logic                        r_m_valid;
    pfra_pkg::t_res              r_m_res;
    pfra_pkg::t_cmd              cmd;
    pfra_pkg::t_res              res;
    logic                        res_valid, res_ready, cfg_wr;
    logic                        reg_sel;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign reg_sel  = paddr[2];

    always_comb begin
        unique case (reg_sel)
            pfra_pkg::REG_START: prdata = {{(pfra_pkg::PDATA_W - pfra_pkg::ADDR_W){1'b0}}, r_start};
            pfra_pkg::REG_END:   prdata = {{(pfra_pkg::PDATA_W - pfra_pkg::ADDR_W){1'b0}}, r_end};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= pfra_pkg::START_RST;
            r_end   <= pfra_pkg::END_RST;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                pfra_pkg::REG_START: r_start <= pwdata[pfra_pkg::ADDR_W-1:0];
                pfra_pkg::REG_END:   r_end   <= pwdata[pfra_pkg::ADDR_W-1:0];
                default:             r_start <= r_start;
            endcase
        end
    end

    assign cmd.op   = i_s_axis_tuser;
    assign cmd.addr = i_s_axis_tdata;

    assign res_ready = !r_m_valid || i_m_axis_tready;

    pfra_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (i_s_axis_tvalid),
        .o_cmd_ready  (o_s_axis_tready),
        .i_cmd        (cmd),
        .i_start_addr (r_start),
        .i_end_addr   (r_end),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_m_res <= res;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_res.page_addr;
    assign o_m_axis_tuser  = r_m_res.status;

endmodule

[src/pfra_engine.sv]
// Sequencer over the reference count memory and the free page bitmap memory.
module pfra_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_ready,
    input  pfra_pkg::t_cmd                i_cmd,
    input  logic [pfra_pkg::ADDR_W-1:0]   i_start_addr,
    input  logic [pfra_pkg::ADDR_W-1:0]   i_end_addr,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output pfra_pkg::t_res                o_res
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ALLOC  = 3'd1;
    localparam logic [2:0] S_FREE   = 3'd2;
    localparam logic [2:0] S_INIT_A = 3'd3;
    localparam logic [2:0] S_INIT_B = 3'd4;
    localparam logic [2:0] S_SWEEP  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    localparam int FI_W = pfra_pkg::FA_W - pfra_pkg::PAGE_SHIFT;

    function automatic logic [pfra_pkg::BIT_W-1:0] msb_word(
        input logic [pfra_pkg::ROW_BITS-1:0] w
    );
        logic [pfra_pkg::BIT_W-1:0] r;
        r = '0;
        for (int i = 0; i < pfra_pkg::ROW_BITS; i++) begin
            if (w[i]) begin
                r = pfra_pkg::BIT_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [pfra_pkg::ROW_W-1:0] msb_rows(
        input logic [pfra_pkg::ROWS-1:0] s
    );
        logic [pfra_pkg::ROW_W-1:0] r;
        r = '0;
        for (int i = 0; i < pfra_pkg::ROWS; i++) begin
            if (s[i]) begin
                r = pfra_pkg::ROW_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [pfra_pkg::PA_W-1:0] page_to_addr(
        input logic [pfra_pkg::IDX_W-1:0] p
    );
        logic [pfra_pkg::FA_W-1:0] full;
        full = pfra_pkg::BASE_ADDR
             + ({{(pfra_pkg::FA_W - pfra_pkg::IDX_W){1'b0}}, p} << pfra_pkg::PAGE_SHIFT);
        return full[pfra_pkg::PA_W-1:0];
    endfunction

    logic [pfra_pkg::CNT_W-1:0]    r_counts [pfra_pkg::NUM_PAGES];
    logic [pfra_pkg::ROW_BITS-1:0] r_bitmap [pfra_pkg::ROWS];

    logic [2:0]                    r_state, n_state;
    logic [pfra_pkg::ROWS-1:0]     r_summary, n_summary;
    logic [pfra_pkg::ROW_W-1:0]    r_row, n_row;
    logic [pfra_pkg::IDX_W-1:0]    r_page, n_page;
    logic [pfra_pkg::IDX_W-1:0]    r_sweep, n_sweep;
    logic [pfra_pkg::ADDR_W-1:0]   r_limit, n_limit;
    logic signed [pfra_pkg::SPAN_W-1:0] r_first, n_first;
    logic signed [pfra_pkg::SPAN_W-1:0] r_span, n_span;
    logic [pfra_pkg::LIM_W-1:0]    r_lo, n_lo;
    logic [pfra_pkg::LIM_W-1:0]    r_hi, n_hi;
    logic                          r_reply, n_reply;
    pfra_pkg::t_res                r_res, n_res;
    logic [pfra_pkg::CNT_W-1:0]    r_cnt_q;
    logic [pfra_pkg::ROW_BITS-1:0] r_bm_q;

    logic                          cnt_we;
    logic [pfra_pkg::IDX_W-1:0]    cnt_waddr, cnt_raddr;
    logic [pfra_pkg::CNT_W-1:0]    cnt_wdata;
    logic                          bm_we;
    logic [pfra_pkg::ROW_W-1:0]    bm_waddr, bm_raddr;
    logic [pfra_pkg::ROW_BITS-1:0] bm_wdata;

    logic [pfra_pkg::FA_W-1:0]     free_off;
    logic [FI_W-1:0]               free_idx;
    logic                          free_below, free_over, free_beyond;
    logic [pfra_pkg::BIT_W-1:0]    alloc_bit;
    logic [pfra_pkg::ROW_BITS-1:0] alloc_word;
    logic [pfra_pkg::IDX_W-1:0]    alloc_page;
    logic [pfra_pkg::ADDR_W-1:0]   d_up, d_down, d_span;
    logic signed [pfra_pkg::SPAN_W-1:0] span_sum, num_pages_s;
    logic                          sweep_in;
    logic [pfra_pkg::ROW_BITS-1:0] sweep_mask;
    logic [pfra_pkg::LIM_W-1:0]    sweep_p;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    assign free_off    = i_cmd.addr - pfra_pkg::BASE_ADDR;
    assign free_idx    = free_off[pfra_pkg::FA_W-1:pfra_pkg::PAGE_SHIFT];
    assign free_below  = (i_cmd.addr < pfra_pkg::BASE_ADDR);
    assign free_over   = (i_cmd.addr >= {{(pfra_pkg::FA_W - pfra_pkg::ADDR_W){1'b0}}, r_limit});
    assign free_beyond = (free_idx >= FI_W'(pfra_pkg::NUM_PAGES));

    assign alloc_bit   = msb_word(r_bm_q);
    assign alloc_word  = r_bm_q & ~(pfra_pkg::ROW_BITS'(1) << alloc_bit);
    assign alloc_page  = {r_row, alloc_bit};

    assign d_up        = i_start_addr - pfra_pkg::BASE_ADDR[pfra_pkg::ADDR_W-1:0];
    assign d_down      = pfra_pkg::BASE_ADDR[pfra_pkg::ADDR_W-1:0] - i_start_addr
                       + pfra_pkg::ADDR_W'(4095);
    assign d_span      = i_end_addr - i_start_addr;
    assign span_sum    = r_first + r_span;
    assign num_pages_s = pfra_pkg::SPAN_W'(pfra_pkg::NUM_PAGES);

    assign sweep_in    = ({1'b0, r_sweep} >= r_lo) && ({1'b0, r_sweep} < r_hi);

    always_comb begin
        sweep_mask = '0;
        sweep_p    = '0;
        for (int b = 0; b < pfra_pkg::ROW_BITS; b++) begin
            sweep_p = {1'b0, r_sweep[pfra_pkg::IDX_W-1:pfra_pkg::BIT_W], pfra_pkg::BIT_W'(b)};
            sweep_mask[b] = (sweep_p >= r_lo) && (sweep_p < r_hi);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_summary = r_summary;
        n_row     = r_row;
        n_page    = r_page;
        n_sweep   = r_sweep;
        n_limit   = r_limit;
        n_first   = r_first;
        n_span    = r_span;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_reply   = r_reply;
        n_res     = r_res;
        cnt_we    = 1'b0;
        cnt_waddr = r_page;
        cnt_wdata = '0;
        cnt_raddr = free_idx[pfra_pkg::IDX_W-1:0];
        bm_we     = 1'b0;
        bm_waddr  = r_row;
        bm_wdata  = '0;
        bm_raddr  = free_idx[pfra_pkg::IDX_W-1:pfra_pkg::BIT_W];

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_res.status    = pfra_pkg::ST_OK;
                    n_res.page_addr = '0;
                    case (i_cmd.op)
                        pfra_pkg::OP_ALLOC: begin
                            bm_raddr = msb_rows(r_summary);
                            n_row    = msb_rows(r_summary);
                            if (r_summary == '0) begin
                                n_res.status = pfra_pkg::ST_OOM;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_ALLOC;
                            end
                        end
                        pfra_pkg::OP_FREE: begin
                            n_page = free_idx[pfra_pkg::IDX_W-1:0];
                            if (free_below) begin
                                n_res.status = pfra_pkg::ST_BELOW;
                                n_state      = S_DONE;
                            end else if (free_over || free_beyond) begin
                                n_res.status = pfra_pkg::ST_NOPAGE;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_FREE;
                            end
                        end
                        pfra_pkg::OP_INIT: begin
                            n_limit = i_end_addr;
                            n_reply = 1'b1;
                            n_state = S_INIT_A;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                bm_we                = 1'b1;
                bm_waddr             = r_row;
                bm_wdata             = alloc_word;
                n_summary[r_row]     = |alloc_word;
                cnt_we               = 1'b1;
                cnt_waddr            = alloc_page;
                cnt_wdata            = pfra_pkg::CNT_W'(1);
                n_res.page_addr      = page_to_addr(alloc_page);
                n_state              = S_DONE;
            end
            S_FREE: begin
                if (r_cnt_q == '0) begin
                    n_res.status = pfra_pkg::ST_FREE;
                end else begin
                    cnt_we    = 1'b1;
                    cnt_waddr = r_page;
                    cnt_wdata = r_cnt_q - pfra_pkg::CNT_W'(1);
                    if (r_cnt_q == pfra_pkg::CNT_W'(1)) begin
                        bm_we    = 1'b1;
                        bm_waddr = r_page[pfra_pkg::IDX_W-1:pfra_pkg::BIT_W];
                        bm_wdata = r_bm_q
                                 | (pfra_pkg::ROW_BITS'(1) << r_page[pfra_pkg::BIT_W-1:0]);
                        n_summary[r_page[pfra_pkg::IDX_W-1:pfra_pkg::BIT_W]] = 1'b1;
                    end
                end
                n_state = S_DONE;
            end
            S_INIT_A: begin
                if ({7'b0, i_start_addr} >= pfra_pkg::BASE_ADDR) begin
                    n_first = $signed({2'b00, d_up[pfra_pkg::ADDR_W-1:pfra_pkg::PAGE_SHIFT]});
                end else begin
                    n_first = -$signed({2'b00, d_down[pfra_pkg::ADDR_W-1:pfra_pkg::PAGE_SHIFT]});
                end
                if (i_end_addr > i_start_addr) begin
                    n_span = $signed({2'b00, d_span[pfra_pkg::ADDR_W-1:pfra_pkg::PAGE_SHIFT]});
                end else begin
                    n_span = '0;
                end
                n_state = S_INIT_B;
            end
            S_INIT_B: begin
                if (r_first < 0) begin
                    n_lo = '0;
                end else if (r_first > num_pages_s) begin
                    n_lo = pfra_pkg::LIM_W'(pfra_pkg::NUM_PAGES);
                end else begin
                    n_lo = r_first[pfra_pkg::LIM_W-1:0];
                end
                if (span_sum <= 0) begin
                    n_hi = '0;
                end else if (span_sum > num_pages_s) begin
                    n_hi = pfra_pkg::LIM_W'(pfra_pkg::NUM_PAGES);
                end else begin
                    n_hi = span_sum[pfra_pkg::LIM_W-1:0];
                end
                n_sweep = '0;
                n_state = S_SWEEP;
            end
            S_SWEEP: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_sweep;
                cnt_wdata = sweep_in ? '0 : pfra_pkg::USED_COUNT;
                if (r_sweep[pfra_pkg::BIT_W-1:0] == '0) begin
                    bm_we     = 1'b1;
                    bm_waddr  = r_sweep[pfra_pkg::IDX_W-1:pfra_pkg::BIT_W];
                    bm_wdata  = sweep_mask;
                    n_summary[r_sweep[pfra_pkg::IDX_W-1:pfra_pkg::BIT_W]] = |sweep_mask;
                end
                if (r_sweep == pfra_pkg::IDX_W'(pfra_pkg::NUM_PAGES - 1)) begin
                    n_state = r_reply ? S_DONE : S_IDLE;
                end else begin
                    n_sweep = r_sweep + pfra_pkg::IDX_W'(1);
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_counts[cnt_waddr] <= cnt_wdata;
        end
        r_cnt_q <= r_counts[cnt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (bm_we) begin
            r_bitmap[bm_waddr] <= bm_wdata;
        end
        r_bm_q <= r_bitmap[bm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_SWEEP;
            r_summary <= '0;
            r_sweep   <= '0;
            r_limit   <= '0;
            r_lo      <= '0;
            r_hi      <= '0;
            r_reply   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_summary <= n_summary;
            r_sweep   <= n_sweep;
            r_limit   <= n_limit;
            r_lo      <= n_lo;
            r_hi      <= n_hi;
            r_reply   <= n_reply;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row   <= n_row;
        r_page  <= n_page;
        r_first <= n_first;
        r_span  <= n_span;
        r_res   <= n_res;
    end

endmodule

[verif/page_frame_refcount_allocator_tb.sv]
// Self-checking testbench for the page frame allocator against a count-map predictor.
module page_frame_refcount_allocator_tb;
    import pfra_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int MAX_PRINTS  = 40;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    // free_address[31:0]
    logic [FA_W-1:0]     i_s_axis_tdata = '0;
    // opcode[1:0]
    logic [OP_W-1:0]     i_s_axis_tuser = OP_NOP;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    // page_address[23:0]
    logic [PA_W-1:0]     o_m_axis_tdata;
    // status[2:0]
    logic [ST_W-1:0]     o_m_axis_tuser;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    logic [CNT_W-1:0]    page_refs [NUM_PAGES];
    logic [ADDR_W-1:0]   mem_limit;
    logic [ADDR_W-1:0]   start_reg;
    logic [ADDR_W-1:0]   end_reg;

    t_cmd                pend_q [$];
    t_res                due_q [$];
    int                  err_n = 0;
    int                  cyc_n = 0;
    int                  n_accepted = 0;
    int                  send_idle = 0;
    int                  recv_idle = 0;
    logic                s_took = 1'b0;
    logic                stall_hold = 1'b0;

    page_frame_refcount_allocator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        if (err_n < MAX_PRINTS) begin
            $display("mismatch at cycle %0d: %s", cyc_n, msg);
        end
        err_n++;
    endtask

    task automatic predict_page_op(input logic [OP_W-1:0] op, input logic [FA_W-1:0] addr);
        t_res        r;
        longint      s;
        longint      e;
        longint      b;
        longint      first;
        longint      span;
        longint      j;
        int          k;
        logic [31:0] idx;
        r.status    = ST_OK;
        r.page_addr = '0;
        case (op)
            OP_ALLOC: begin
                r.status = ST_OOM;
                for (k = NUM_PAGES - 1; k >= 0; k--) begin
                    if (page_refs[k] == '0) begin
                        page_refs[k] = 7'd1;
                        r.status     = ST_OK;
                        r.page_addr  = PA_W'(BASE_ADDR + (32'(k) << PAGE_SHIFT));
                        break;
                    end
                end
            end
            OP_FREE: begin
                if (addr < BASE_ADDR) begin
                    r.status = ST_BELOW;
                end else if (addr >= {7'd0, mem_limit}) begin
                    r.status = ST_NOPAGE;
                end else begin
                    idx = (addr - BASE_ADDR) >> PAGE_SHIFT;
                    if (idx >= 32'(NUM_PAGES)) begin
                        r.status = ST_NOPAGE;
                    end else if (page_refs[idx] == '0) begin
                        r.status = ST_FREE;
                    end else begin
                        page_refs[idx] = page_refs[idx] - 1'b1;
                    end
                end
            end
            OP_INIT: begin
                mem_limit = end_reg;
                for (k = 0; k < NUM_PAGES; k++) begin
                    page_refs[k] = USED_COUNT;
                end
                s = longint'(start_reg);
                e = longint'(end_reg);
                b = longint'(BASE_ADDR);
                // A start below the base gives a negative first page, rounded away from the map.
                first = (s >= b) ? (s - b) / 4096 : -((b - s + 4095) / 4096);
                span  = (e > s) ? (e - s) / 4096 : 0;
                for (j = first; j < first + span; j++) begin
                    if (j >= 0 && j < NUM_PAGES) begin
                        page_refs[j] = '0;
                    end
                end
            end
            default: begin
            end
        endcase
        due_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        cyc_n++;
        if (cyc_n == CYCLE_LIMIT) begin
            $display("page_frame_refcount_allocator_tb failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            predict_page_op(i_s_axis_tuser, i_s_axis_tdata);
            s_took = 1'b1;
            n_accepted++;
        end
    end

    always @(negedge i_clk) begin : drive_words
        t_cmd nxt;
        if (!i_s_axis_tvalid || s_took) begin
            if (pend_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                nxt = pend_q.pop_front();
                i_s_axis_tuser  <= nxt.op;
                i_s_axis_tdata  <= nxt.addr;
                i_s_axis_tvalid <= 1'b1;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
        s_took = 1'b0;
        i_m_axis_tready <= !stall_hold && ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge i_clk) begin : check_results
        t_res want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (due_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected word, status %0d address %h",
                                        o_m_axis_tuser, o_m_axis_tdata));
            end else begin
                want = due_q.pop_front();
                if (o_m_axis_tuser !== want.status) begin
                    flag_mismatch($sformatf("status %0d, wanted %0d",
                                            o_m_axis_tuser, want.status));
                end
                if (o_m_axis_tdata !== want.page_addr) begin
                    flag_mismatch($sformatf("page address %h, wanted %h",
                                            o_m_axis_tdata, want.page_addr));
                end
            end
        end
    end

    // The receiver holds off for a long stretch so that the block backs up its input.
    // The stretch outlasts an initialise sweep, so the output side fills up in any case.
    initial begin
        wait (n_accepted >= 60);
        stall_hold = 1'b1;
        repeat (NUM_PAGES + 400) @(posedge i_clk);
        stall_hold = 1'b0;
    end

    task automatic push_cmd(input logic [OP_W-1:0] op, input logic [FA_W-1:0] addr);
        t_cmd c;
        c.op   = op;
        c.addr = addr;
        pend_q.push_back(c);
    endtask

    task automatic queue_mix(input int n, input int top_pg, input int alloc_pct,
                             input logic [31:0] lim);
        t_cmd c;
        int   taken;
        int   r;
        int   k;
        taken = 0;
        for (int i = 0; i < n; i++) begin
            r      = $urandom_range(0, 99);
            c.addr = $urandom();
            if (r < alloc_pct) begin
                c.op = OP_ALLOC;
                taken++;
            end else if (r < 82) begin
                // Mostly pages that recent allocations are likely to have handed out.
                c.op = OP_FREE;
                k    = top_pg - $urandom_range(0, taken + 3);
                if (k < 0) begin
                    k = $urandom_range(0, NUM_PAGES - 1);
                end
                c.addr = BASE_ADDR + (32'(k) << PAGE_SHIFT) + $urandom_range(0, 4095);
            end else if (r < 94) begin
                c.op = OP_FREE;
                case ($urandom_range(0, 4))
                    0: c.addr = $urandom_range(0, BASE_ADDR - 1);
                    1: c.addr = lim - 32'd4096 + $urandom_range(0, 8191);
                    2: c.addr = BASE_ADDR + (32'($urandom_range(0, NUM_PAGES - 1)) << PAGE_SHIFT)
                                + $urandom_range(0, 4095);
                    3: c.addr = 32'h0100_0000 + $urandom_range(0, 32'h00FF_FFFF);
                    default: begin
                    end
                endcase
            end else if (r < 97) begin
                c.op  = OP_INIT;
                taken = 0;
            end else begin
                c.op = OP_NOP;
            end
            pend_q.push_back(c);
        end
    endtask

    task automatic drain_wait();
        while (pend_q.size() > 0 || i_s_axis_tvalid || due_q.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [ADDR_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_START) begin
            start_reg = val;
        end else begin
            end_reg = val;
        end
    endtask

    task automatic set_window(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
        drain_wait();
        write_reg(REG_START, lo);
        write_reg(REG_END, hi);
        push_cmd(OP_INIT, $urandom());
    endtask

    initial begin
        for (int k = 0; k < NUM_PAGES; k++) begin
            page_refs[k] = USED_COUNT;
        end
        mem_limit = '0;
        start_reg = START_RST;
        end_reg   = END_RST;
        send_idle = 6;
        recv_idle = 70;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Before any initialise the limit is zero and every page is used.
        push_cmd(OP_FREE, BASE_ADDR);
        push_cmd(OP_FREE, 32'h0000_0000);
        push_cmd(OP_FREE, BASE_ADDR - 1);
        push_cmd(OP_ALLOC, 32'hFFFF_FFFF);
        push_cmd(OP_NOP, 32'hFFFF_FFFF);
        push_cmd(OP_INIT, 32'h5555_AAAA);
        push_cmd(OP_ALLOC, 32'h0000_0000);
        push_cmd(OP_ALLOC, 32'h0000_0000);
        push_cmd(OP_FREE, 32'h00FF_F000);
        push_cmd(OP_FREE, 32'h00FF_FABC);
        push_cmd(OP_FREE, 32'h00FF_FFFF);
        push_cmd(OP_FREE, 32'h00FF_EFFF);
        push_cmd(OP_FREE, 32'h0100_0000);
        push_cmd(OP_FREE, 32'hFFFF_FFFF);
        push_cmd(OP_FREE, 32'h8000_0000);
        push_cmd(OP_FREE, BASE_ADDR);
        push_cmd(OP_NOP, 32'h0000_0000);
        push_cmd(OP_ALLOC, 32'hAAAA_5555);
        queue_mix(150, NUM_PAGES - 1, 40, 32'h0100_0000);

        // Eight pages only, so allocation runs dry often.
        set_window(25'h020_0000, 25'h020_8000);
        queue_mix(120, 263, 55, 32'h0020_8000);

        drain_wait();
        send_idle = 70;
        recv_idle = 6;
        // Start below the base and limit beyond the end of the map.
        set_window(25'h00F_F800, 25'h1FF_FFFF);
        push_cmd(OP_FREE, 32'h0100_0000);
        push_cmd(OP_FREE, 32'h01FF_FFFE);
        push_cmd(OP_FREE, 32'h000F_F800);
        queue_mix(120, NUM_PAGES - 1, 40, 32'h01FF_FFFF);

        set_window(25'h100_0000, 25'h100_0000);
        push_cmd(OP_ALLOC, 32'h0000_0000);
        push_cmd(OP_FREE, 32'h00FF_F123);
        push_cmd(OP_FREE, 32'h0100_0000);

        // End below start clears nothing.
        set_window(25'h080_0000, 25'h040_0000);
        push_cmd(OP_ALLOC, 32'h0000_0000);
        push_cmd(OP_FREE, 32'h0050_0000);

        set_window(25'h010_0000, 25'h010_0000);
        push_cmd(OP_FREE, BASE_ADDR);
        push_cmd(OP_ALLOC, 32'h0000_0000);

        drain_wait();
        send_idle = 0;
        recv_idle = 0;
        set_window(25'h010_0800, 25'h0F0_0000);
        queue_mix(150, 3582, 40, 32'h00F0_0000);

        set_window(25'h010_1000, 25'h010_4000);
        queue_mix(80, 3, 55, 32'h0010_4000);

        drain_wait();
        repeat (NUM_PAGES + 16) @(posedge i_clk);
        if (due_q.size() != 0) begin
            flag_mismatch($sformatf("%0d results never arrived", due_q.size()));
        end
        if (err_n == 0) begin
            $display("page_frame_refcount_allocator_tb passed");
        end else begin
            $display("page_frame_refcount_allocator_tb failed");
        end
        $finish;
    end

endmodule
